// ===== rtl/core/ctp_pkg.sv =====
// Types, character codes and per-character parse functions for the color text parser.
package ctp_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  localparam logic [8:0]  ACC_SAT     = 9'd256;
  localparam logic [11:0] ACC_SAT_W   = 12'd256;
  localparam logic [2:0]  HEX_LONG    = 3'd6;
  localparam logic [2:0]  HEX_SHORT   = 3'd3;
  localparam logic [2:0]  HEX_CNT_MAX = 3'd7;
  localparam logic [1:0]  LAST_FIELD  = 2'd2;
  localparam logic [3:0]  HEX_TEN     = 4'd10;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_HEX   = 4'b0010,
    PH_DEC   = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last;
  } ctp_in_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ctp_out_t;

  typedef struct packed {
    phase_t          phase;
    logic [2:0]      hex_cnt;
    logic [1:0]      field_idx;
    logic [8:0]      acc;
    logic            digit_seen;
    logic            minus_seen;
    logic [2:0][7:0] chan;
    logic            failed;
  } ctp_state_t;

  localparam ctp_state_t CTP_RESET = '{
    phase:      PH_START,
    hex_cnt:    3'd0,
    field_idx:  2'd0,
    acc:        9'd0,
    digit_seen: 1'b0,
    minus_seen: 1'b0,
    chan:       '0,
    failed:     1'b0
  };

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

  function automatic ctp_state_t hex_char(ctp_state_t s, logic [7:0] c);
    ctp_state_t r;
    logic [4:0] hv;
    r  = s;
    hv = hex_nibble(c);
    if (!hv[4]) begin
      r.failed = 1'b1;
    end else begin
      if (s.hex_cnt < HEX_LONG) begin
        if (!s.hex_cnt[0]) begin
          r.chan[s.hex_cnt[2:1]][7:4] = hv[3:0];
        end else begin
          r.chan[s.hex_cnt[2:1]][3:0] = hv[3:0];
        end
      end
      if (s.hex_cnt != HEX_CNT_MAX) begin
        r.hex_cnt = s.hex_cnt + 3'd1;
      end
    end
    return r;
  endfunction

  function automatic ctp_state_t finish_num(ctp_state_t s);
    ctp_state_t r;
    r = s;
    // acc never exceeds 256, so bit 8 means out of range
    if ((s.minus_seen && s.acc != 9'd0) || s.acc[8]) begin
      r.failed = 1'b1;
    end else begin
      r.chan[s.field_idx] = s.acc[7:0];
      r.field_idx         = s.field_idx + 2'd1;
      r.acc               = 9'd0;
      r.digit_seen        = 1'b0;
      r.minus_seen        = 1'b0;
      if (s.field_idx == LAST_FIELD) begin
        r.phase = PH_DONE;
      end
    end
    return r;
  endfunction

  function automatic ctp_state_t dec_char(ctp_state_t s, logic [7:0] c);
    ctp_state_t  r;
    logic        is_dig;
    logic [3:0]  d;
    logic [11:0] v;
    logic        go;
    r      = s;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = c[3:0];
    v      = {3'd0, s.acc} * {8'd0, HEX_TEN} + {8'd0, d};
    go     = 1'b1;
    if (s.digit_seen) begin
      if (is_dig) begin
        r.acc = (v > ACC_SAT_W) ? ACC_SAT : v[8:0];
        go    = 1'b0;
      end else begin
        // the terminating character also starts the next number
        r = finish_num(r);
        if (r.failed || r.phase == PH_DONE) begin
          go = 1'b0;
        end
      end
    end
    if (go) begin
      if (!r.minus_seen && c == CH_SPACE) begin
        r.minus_seen = 1'b0;
      end else if (!r.minus_seen && c == CH_MINUS) begin
        r.minus_seen = 1'b1;
      end else if (is_dig) begin
        r.digit_seen = 1'b1;
        r.acc        = {5'd0, d};
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ctp_step.sv =====
// Next-state and result logic for one character word of the color parser.
module ctp_step
  import ctp_pkg::*;
(
  input  ctp_state_t st_i,
  input  ctp_in_t    in_i,
  output ctp_state_t st_nxt_o,
  output ctp_out_t   res_o
);

  ctp_state_t s_char;
  ctp_state_t s_end;
  ctp_state_t s_pre;
  logic       ok;

  always_comb begin
    s_pre  = st_i;
    s_char = st_i;
    if (in_i.char_present && !st_i.failed) begin
      if (st_i.phase == PH_START && in_i.char_code != CH_HASH) begin
        s_pre.phase = PH_DEC;
      end
      unique case (s_pre.phase)
        PH_START: s_char.phase = PH_HEX;
        PH_HEX:   s_char = hex_char(s_pre, in_i.char_code);
        PH_DEC:   s_char = dec_char(s_pre, in_i.char_code);
        PH_DONE:  s_char = s_pre;
        default:  s_char = s_pre;
      endcase
    end
  end

  always_comb begin
    s_end = s_char;
    // close a pending number at end of string
    if (!s_char.failed && s_char.phase == PH_DEC && s_char.digit_seen) begin
      s_end = finish_num(s_char);
    end
  end

  always_comb begin
    ok    = 1'b0;
    res_o = '0;
    if (!s_end.failed) begin
      if (s_end.phase == PH_DONE ||
          (s_end.phase == PH_HEX && s_end.hex_cnt == HEX_LONG)) begin
        ok          = 1'b1;
        res_o.red   = s_end.chan[0];
        res_o.green = s_end.chan[1];
        res_o.blue  = s_end.chan[2];
      end else if (s_end.phase == PH_HEX && s_end.hex_cnt == HEX_SHORT) begin
        ok          = 1'b1;
        res_o.red   = {s_end.chan[0][7:4], s_end.chan[0][7:4]};
        res_o.green = {s_end.chan[0][3:0], s_end.chan[0][3:0]};
        res_o.blue  = {s_end.chan[1][7:4], s_end.chan[1][7:4]};
      end
    end
    res_o.ok = ok;
  end

  assign st_nxt_o = in_i.last ? CTP_RESET : s_char;

endmodule

// ===== rtl/core/ctp_out_buf.sv =====
// Result register for the color parser output channel.
module ctp_out_buf
  import ctp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ctp_out_t push_data,
  output logic     free,
  output logic     out_valid,
  input  logic     out_ready,
  output ctp_out_t out_data
);

  logic     valid_r;
  logic     valid_nxt;
  ctp_out_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = push || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/core/color_text_parser_core.sv =====
// Top level of the color text parser: input register, parse state and result buffer.
// Takes a color string one character word per cycle ("#rgb", "#rrggbb" or three
// decimal numbers 0..255 with optional leading spaces; '-' is accepted only before
// a zero) and returns one word with ok, red, green and blue after the word marked
// last. Each word passes from the input register through one step of the parse
// logic into the state registers, so the sustained rate is one word per clock
// while no last word waits. A last word waits in the input register only while the
// result register still holds an untaken result; its result is then registered there.
module color_text_parser_core
  import ctp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ctp_out_t out_data
);

  logic       in_valid_r;
  logic       in_valid_nxt;
  ctp_in_t    in_data_r;
  ctp_state_t st_r;
  ctp_state_t st_nxt;
  ctp_out_t   res;
  logic       out_free;
  logic       advance;
  logic       push;

  ctp_step u_step (
    .st_i     (st_r),
    .in_i     (in_data_r),
    .st_nxt_o (st_nxt),
    .res_o    (res)
  );

  ctp_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // hold a last word until the result register can take it
  assign advance      = in_valid_r && (!in_data_r.last || out_free);
  assign push         = advance && in_data_r.last;
  assign in_ready     = !in_valid_r || advance;
  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= CTP_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (st_r.phase == PH_START && !st_r.failed && st_r.field_idx == 2'd0))
    else $error("parse state not cleared after end of string");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_DONE) |-> (st_r.field_idx == 2'd3))
    else $error("decimal parse done without three numbers");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_START) |-> (st_r.hex_cnt == 3'd0 && st_r.field_idx == 2'd0
                                  && !st_r.digit_seen && !st_r.minus_seen))
    else $error("stale parse state at start of string");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(st_r)))
    else $error("parse state moved while word stalled");

endmodule
